// ===== src/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg: shared definitions for the work-stealing deque
// Widths, operation codes, result payload type and default sizes.
// ----------------------------------------------------------------------------
package wsd_pkg;

   // default ring size, must be a power of two
   localparam int unsigned CAPACITY_DEFAULT = 256;

   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned HANDLE_W = 32;
   localparam int unsigned CNT_W    = 32;
   localparam int unsigned OCC_W    = 9;

   // result queue depth, power of two
   localparam int unsigned RSP_FIFO_DEPTH = 4;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STEAL = 2'd2;

   typedef struct packed {
      logic [HANDLE_W-1:0] job_out;
      logic                got_job;
      logic                refused_full;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

endpackage

// ===== src/wsd_req_if.sv =====
// ----------------------------------------------------------------------------
// wsd_req_if: operation channel
// valid/ready channel carrying one deque operation per beat.
// ----------------------------------------------------------------------------
interface wsd_req_if;
   logic                        valid;
   logic                        ready;
   logic [wsd_pkg::FUNC_W-1:0]   func;
   logic [wsd_pkg::HANDLE_W-1:0] job_handle;

   modport source (output valid, output func, output job_handle, input ready);
   modport sink   (input valid, input func, input job_handle, output ready);
endinterface

// ===== src/wsd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// wsd_rsp_if: result channel
// valid/ready channel carrying one operation result per beat.
// ----------------------------------------------------------------------------
interface wsd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wsd_pkg::HANDLE_W-1:0] job_out;
   logic                        got_job;
   logic                        refused_full;
   logic [wsd_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output job_out, output got_job,
                   output refused_full, output occupancy, input ready);
   modport sink   (input valid, input job_out, input got_job,
                   input refused_full, input occupancy, output ready);
endinterface

// ===== src/wsd_slot_ram.sv =====
// ----------------------------------------------------------------------------
// wsd_slot_ram: handle storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wsd_slot_ram #(
   parameter int unsigned DEPTH  = wsd_pkg::CAPACITY_DEFAULT,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [wsd_pkg::HANDLE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [wsd_pkg::HANDLE_W-1:0] rd_data
);

   logic [wsd_pkg::HANDLE_W-1:0] slot_mem_ff [DEPTH];
   logic [wsd_pkg::HANDLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/wsd_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// wsd_rsp_fifo: result queue
// Small queue that decouples the deque core from result back-pressure.
// ----------------------------------------------------------------------------
module wsd_rsp_fifo (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          push,
   input  wsd_pkg::rsp_type                              push_data,
   input  logic                                          pop,
   output logic                                          out_valid,
   output wsd_pkg::rsp_type                              out_data,
   output logic [$clog2(wsd_pkg::RSP_FIFO_DEPTH+1)-1:0]  level
);

   localparam int unsigned DEPTH = wsd_pkg::RSP_FIFO_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned LVL_W = $clog2(DEPTH + 1);

   wsd_pkg::rsp_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic              do_pop;

   assign out_valid = (level_ff != '0);
   assign do_pop    = pop && out_valid;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign level     = level_ff;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + LVL_W'(push) - LVL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/work_stealing_deque_core.sv =====
// ----------------------------------------------------------------------------
// work_stealing_deque_core: fixed-capacity work-stealing deque
// Ring of job handles with owner push/pop at the bottom and steal at the top.
// ----------------------------------------------------------------------------
// One operation is taken per beat on req_bus and every operation yields exactly
// one result beat on rsp_bus, in order. The block takes a new operation every
// clock cycle while ready is high; a result passes through the slot memory
// read register and then the result queue before it appears. The rate is set
// by the slot memory, which gives one write or one registered read per cycle,
// and each operation touches at most one slot. A four-entry result queue lets
// the block keep accepting while results wait, and ready drops only once the
// queue and the in-flight stage would fill. The slot store has no reset and
// no clearing pass; a pop or steal never reaches a slot that no push wrote.
// Fill level is the signed difference of the bottom and top counters: zero or
// negative counts as empty, at or above CAPACITY as full. A push to a full
// deque is refused and flagged, a pop or steal on an empty one returns got_job
// low and a zero handle. CAPACITY must be a power of two.
// ----------------------------------------------------------------------------
module work_stealing_deque_core #(
   parameter int unsigned CAPACITY = wsd_pkg::CAPACITY_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   wsd_req_if.sink    req_bus,
   wsd_rsp_if.source  rsp_bus
);

   localparam int unsigned ADDR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = wsd_pkg::CNT_W;
   localparam int unsigned OCC_W  = wsd_pkg::OCC_W;
   localparam int unsigned LVL_W  = $clog2(wsd_pkg::RSP_FIFO_DEPTH + 1);
   localparam logic [CNT_W-1:0]   CAP_CNT   = CNT_W'(CAPACITY);
   localparam logic [LVL_W:0]     FIFO_ROOM = (LVL_W+1)'(wsd_pkg::RSP_FIFO_DEPTH);

   // clamp the signed counter difference to 0..CAPACITY, reported mod 512
   function automatic logic [OCC_W-1:0] clamp_fill(input logic [CNT_W-1:0] diff);
      logic [OCC_W-1:0] occ;
      if (diff[CNT_W-1]) begin
         occ = '0;
      end else if (diff > CAP_CNT) begin
         occ = CAP_CNT[OCC_W-1:0];
      end else begin
         occ = diff[OCC_W-1:0];
      end
      return occ;
   endfunction

   // end counters
   logic [CNT_W-1:0] bottom_ff, bottom_in;
   logic [CNT_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] bottom_dec;
   logic [CNT_W-1:0] fill_diff, next_diff;
   logic             is_empty, is_full;

   // decoded operation
   logic accept;
   logic do_push, do_pop, do_steal, refused;

   // in-flight stage, waiting on the slot read
   logic             s1_valid_ff;
   logic             s1_got_ff;
   logic             s1_refused_ff;
   logic [OCC_W-1:0] s1_occ_ff;

   // slot memory
   logic [ADDR_W-1:0]            rd_addr;
   logic [wsd_pkg::HANDLE_W-1:0] rd_data;

   // result queue
   wsd_pkg::rsp_type  fifo_in_data;
   wsd_pkg::rsp_type  fifo_out_data;
   logic              fifo_out_valid;
   logic [LVL_W-1:0]  fifo_level;
   logic [LVL_W:0]    pending;

   // fill level from the counters, signed view so wrap does not fool it
   assign fill_diff  = bottom_ff - top_ff;
   assign is_empty   = fill_diff[CNT_W-1] || (fill_diff == '0);
   assign is_full    = !fill_diff[CNT_W-1] && (fill_diff >= CAP_CNT);
   assign bottom_dec = bottom_ff - CNT_W'(1);

   // ready while the queue can absorb everything already in flight
   assign pending       = (LVL_W+1)'(fifo_level) + (LVL_W+1)'(s1_valid_ff);
   assign req_bus.ready = (pending < FIFO_ROOM);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      do_push  = 1'b0;
      do_pop   = 1'b0;
      do_steal = 1'b0;
      refused  = 1'b0;
      unique case (req_bus.func)
         wsd_pkg::FUNC_PUSH: begin
            do_push = accept && !is_full;
            refused = is_full;
         end
         wsd_pkg::FUNC_POP: begin
            do_pop = accept && !is_empty;
         end
         wsd_pkg::FUNC_STEAL: begin
            do_steal = accept && !is_empty;
         end
         default: begin
            // unused code, no operation
         end
      endcase
   end

   // counter updates; at most one end moves per beat
   always_comb begin
      priority if (do_push) begin
         bottom_in = bottom_ff + CNT_W'(1);
      end else if (do_pop) begin
         bottom_in = bottom_dec;
      end else begin
         bottom_in = bottom_ff;
      end
      top_in    = do_steal ? top_ff + CNT_W'(1) : top_ff;
      next_diff = bottom_in - top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ff   <= '0;
         top_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         bottom_ff   <= bottom_in;
         top_ff      <= top_in;
         s1_valid_ff <= accept;
      end
   end

   // result flags travel alongside the slot read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_got_ff     <= do_pop || do_steal;
         s1_refused_ff <= refused;
         s1_occ_ff     <= clamp_fill(next_diff);
      end
   end

   // pop reads the slot below bottom, steal the slot at top
   assign rd_addr = do_pop ? bottom_dec[ADDR_W-1:0] : top_ff[ADDR_W-1:0];

   wsd_slot_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (bottom_ff[ADDR_W-1:0]),
      .wr_data (req_bus.job_handle),
      .rd_en   (do_pop || do_steal),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handle is zero whenever nothing was taken
   always_comb begin
      fifo_in_data.job_out      = s1_got_ff ? rd_data : '0;
      fifo_in_data.got_job      = s1_got_ff;
      fifo_in_data.refused_full = s1_refused_ff;
      fifo_in_data.occupancy    = s1_occ_ff;
   end

   wsd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (fifo_in_data),
      .pop       (rsp_bus.ready),
      .out_valid (fifo_out_valid),
      .out_data  (fifo_out_data),
      .level     (fifo_level)
   );

   assign rsp_bus.valid        = fifo_out_valid;
   assign rsp_bus.job_out      = fifo_out_data.job_out;
   assign rsp_bus.got_job      = fifo_out_data.got_job;
   assign rsp_bus.refused_full = fifo_out_data.refused_full;
   assign rsp_bus.occupancy    = fifo_out_data.occupancy;

endmodule

// ===== src/wsd_checker.sv =====
// ----------------------------------------------------------------------------
// wsd_checker: port-level checks for the work-stealing deque
// Watches the operation and result channels of the core over time.
// ----------------------------------------------------------------------------
module wsd_checker #(
   parameter int unsigned CAPACITY = wsd_pkg::CAPACITY_DEFAULT
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [wsd_pkg::HANDLE_W-1:0] rsp_job_out,
   input logic                        rsp_got_job,
   input logic                        rsp_refused_full,
   input logic [wsd_pkg::OCC_W-1:0]    rsp_occupancy
);

   localparam logic [wsd_pkg::OCC_W-1:0] FULL_OCC = wsd_pkg::OCC_W'(CAPACITY);

   logic [3:0] outstanding_ff, outstanding_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff + 4'(req_beat) - 4'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // no result while reset is applied or just after
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // every result beat answers an earlier accepted operation
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("result with no operation outstanding");

   // a refused push only happens at full occupancy
   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_refused_full) |-> (rsp_occupancy == FULL_OCC))
      else $error("push refused while not full");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_job_out)
         && $stable(rsp_got_job) && $stable(rsp_refused_full)
         && $stable(rsp_occupancy)))
      else $error("stalled result changed");

endmodule

bind work_stealing_deque_core wsd_checker #(
   .CAPACITY (CAPACITY)
) u_wsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_job_out      (rsp_bus.job_out),
   .rsp_got_job      (rsp_bus.got_job),
   .rsp_refused_full (rsp_bus.refused_full),
   .rsp_occupancy    (rsp_bus.occupancy)
);
